// ----- design/assert_macros.svh -----
// Assertion macros shared by the handle allocator RTL.
// Depends on nothing; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Invariant on state, checked every cycle outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

// ----- design/gha_pkg.sv -----
// Shared types and constants of the generational handle allocator.
// Used by gha_ctrl, gha_datapath and generational_handle_allocator_unit.
package gha_pkg;

  // Default slot count
  localparam int SLOTS_DEFAULT = 1024;

  // Field widths
  localparam int SLOT_FW  = 10;
  localparam int GEN_W    = 32;
  localparam int GROUP_W  = 8;
  localparam int PAGE_W   = 16;
  localparam int ROW_W    = 16;
  localparam int LOC_W    = GROUP_W + PAGE_W + ROW_W;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 88;

  // Request kinds
  localparam logic MODE_CREATE  = 1'b0;
  localparam logic MODE_DESTROY = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // First generation of a fresh slot
  localparam logic [GEN_W-1:0] GEN_FIRST = 32'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_GEN,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the request
    logic read;      // read stack top, generation and location of handle
    logic gen_pop;   // read generation of the popped slot
    logic finish;    // update stores and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_create;
    logic stack_nonempty;
    logic out_busy;
  } stat_t;

endpackage

// ----- design/gha_ctrl.sv -----
// Request sequencer of the generational handle allocator.
// Depends on gha_pkg.
module gha_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  gha_pkg::stat_t stat,
  output gha_pkg::cmd_t  cmd
);

  gha_pkg::state_t state;
  gha_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gha_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gha_pkg::S_IDLE: begin
        if (s_tvalid) state_next = gha_pkg::S_READ;
      end
      gha_pkg::S_READ: begin
        // a reused slot needs its stored generation
        if (stat.is_create && stat.stack_nonempty) state_next = gha_pkg::S_GEN;
        else state_next = gha_pkg::S_FINISH;
      end
      gha_pkg::S_GEN: begin
        state_next = gha_pkg::S_FINISH;
      end
      gha_pkg::S_FINISH: begin
        if (!stat.out_busy) state_next = gha_pkg::S_IDLE;
      end
      default: state_next = gha_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      gha_pkg::S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      gha_pkg::S_READ:   cmd.read    = 1'b1;
      gha_pkg::S_GEN:    cmd.gen_pop = 1'b1;
      gha_pkg::S_FINISH: cmd.finish  = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- design/gha_datapath.sv -----
// Datapath of the generational handle allocator: slot stores, free stack,
// counters and result register. Depends on gha_pkg.
module gha_datapath #(
  parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gha_pkg::cmd_t                 cmd,
  output gha_pkg::stat_t                stat,
  input  logic [gha_pkg::DATA_W-1:0]    s_tdata,
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gha_pkg::DATA_W-1:0]    m_tdata,
  output logic [gha_pkg::STATUS_W-1:0]  m_tuser,
  output logic [$clog2(SLOTS+1)-1:0]    used_cnt,
  output logic [$clog2(SLOTS+1)-1:0]    free_cnt
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS+1);
  localparam int GEN_W  = gha_pkg::GEN_W;
  localparam int LOC_W  = gha_pkg::LOC_W;

  // Stores
  logic [GEN_W-1:0]  gen_mem   [SLOTS];
  logic [LOC_W-1:0]  loc_mem   [SLOTS];
  logic [SLOT_W-1:0] stack_mem [SLOTS];

  // Latched request
  logic                       req_mode;
  logic [gha_pkg::SLOT_FW-1:0] req_slot;
  logic [GEN_W-1:0]           req_gen;
  logic [LOC_W-1:0]           req_loc;

  // Registered read data
  logic [SLOT_W-1:0] stack_rd;
  logic [GEN_W-1:0]  gen_rd;
  logic [LOC_W-1:0]  loc_rd;

  logic [SLOT_W-1:0] req_idx;
  logic [CNT_W-1:0]  free_dec;
  logic [SLOT_W-1:0] top_idx;
  logic [SLOT_W-1:0] gen_raddr;
  logic              stack_full;
  logic              used_avail;
  logic              handle_ok;
  logic [GEN_W-1:0]  gen_inc;

  // Finish-step decisions
  logic                        gen_we;
  logic [SLOT_W-1:0]           gen_waddr;
  logic [GEN_W-1:0]            gen_wdata;
  logic                        loc_we;
  logic [SLOT_W-1:0]           loc_waddr;
  logic                        push;
  logic                        pop;
  logic                        fresh;
  logic [gha_pkg::STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]           res_slot;
  logic [GEN_W-1:0]            res_gen;
  logic [LOC_W-1:0]            res_loc;

  assign req_idx    = SLOT_W'(req_slot);
  assign free_dec   = free_cnt - CNT_W'(1);
  assign top_idx    = free_dec[SLOT_W-1:0];
  assign gen_raddr  = cmd.gen_pop ? stack_rd : req_idx;
  assign stack_full = (free_cnt == CNT_W'(SLOTS));
  assign used_avail = (used_cnt != CNT_W'(SLOTS));
  assign gen_inc    = (gen_rd + GEN_W'(1) == '0) ? gha_pkg::GEN_FIRST : gen_rd + GEN_W'(1);
  assign handle_ok  = (req_gen != '0) && (32'(req_slot) < SLOTS) &&
                      (32'(req_slot) < 32'(used_cnt)) && (gen_rd == req_gen);

  assign stat.is_create      = (req_mode == gha_pkg::MODE_CREATE);
  assign stat.stack_nonempty = (free_cnt != '0);
  assign stat.out_busy       = m_tvalid && !m_tready;

  // Request capture; tdata holds slot, generation, group, page, row
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode <= s_tuser;
      req_slot <= s_tdata[9:0];
      req_gen  <= s_tdata[41:10];
      req_loc  <= {s_tdata[49:42], s_tdata[65:50], s_tdata[81:66]};
    end
  end

  // Store reads
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      stack_rd <= stack_mem[top_idx];
      loc_rd   <= loc_mem[req_idx];
    end
    if (cmd.read || cmd.gen_pop) begin
      gen_rd <= gen_mem[gen_raddr];
    end
  end

  // Finish-step outcome
  always_comb begin
    gen_we     = 1'b0;
    gen_waddr  = req_idx;
    gen_wdata  = gen_inc;
    loc_we     = 1'b0;
    loc_waddr  = stack_rd;
    push       = 1'b0;
    pop        = 1'b0;
    fresh      = 1'b0;
    res_status = gha_pkg::ST_OK;
    res_slot   = '0;
    res_gen    = '0;
    res_loc    = req_loc;
    if (req_mode == gha_pkg::MODE_CREATE) begin
      priority if (stat.stack_nonempty) begin
        pop      = 1'b1;
        loc_we   = 1'b1;
        res_slot = stack_rd;
        res_gen  = gen_rd;
      end else if (used_avail) begin
        fresh     = 1'b1;
        loc_we    = 1'b1;
        loc_waddr = used_cnt[SLOT_W-1:0];
        gen_we    = 1'b1;
        gen_waddr = used_cnt[SLOT_W-1:0];
        gen_wdata = gha_pkg::GEN_FIRST;
        res_slot  = used_cnt[SLOT_W-1:0];
        res_gen   = gha_pkg::GEN_FIRST;
      end else begin
        res_status = gha_pkg::ST_FULL;
      end
    end else begin
      res_slot = req_idx;
      if (handle_ok) begin
        gen_we  = 1'b1;
        push    = !stack_full;
        res_loc = loc_rd;
      end else begin
        res_status = gha_pkg::ST_BAD;
        res_loc    = '0;
      end
    end
  end

  // Store writes
  always_ff @(posedge clk) begin
    if (cmd.finish && gen_we) gen_mem[gen_waddr] <= gen_wdata;
    if (cmd.finish && loc_we) loc_mem[loc_waddr] <= req_loc;
    if (cmd.finish && push) stack_mem[free_cnt[SLOT_W-1:0]] <= req_idx;
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      used_cnt <= '0;
      free_cnt <= '0;
    end else if (cmd.finish) begin
      if (fresh) used_cnt <= used_cnt + CNT_W'(1);
      if (pop) free_cnt <= free_dec;
      else if (push) free_cnt <= free_cnt + CNT_W'(1);
    end
  end

  // Result register; the destroy path echoes the handle slot as given
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tuser <= res_status;
      m_tdata <= {6'b0,
                  res_loc[gha_pkg::ROW_W-1:0],
                  res_loc[gha_pkg::ROW_W +: gha_pkg::PAGE_W],
                  res_loc[gha_pkg::ROW_W+gha_pkg::PAGE_W +: gha_pkg::GROUP_W],
                  res_gen,
                  (req_mode == gha_pkg::MODE_DESTROY) ? req_slot
                                                      : gha_pkg::SLOT_FW'(res_slot)};
    end
  end

endmodule

// ----- design/generational_handle_allocator_unit.sv -----
// Generational handle allocator, top level; depends on gha_pkg, gha_ctrl,
// gha_datapath and assert_macros.svh.
// Input channel s_*: one request per transfer, s_tuser selects create (0) or
// destroy (1); s_tdata carries the handle and the location to store.
// Output channel m_*: one result per request, in request order; m_tuser is
// the status (ok, no free slot, stale handle), m_tdata the handle and location.
// Sequence: a request is taken in the idle step, its stores are read in the
// read step, a create that reuses a freed slot then reads that slot's
// generation, and the result register loads in the finish step, which sets
// m_tvalid. One request at a time: the next request is taken only once the
// previous one has passed its capture, read and finish steps, plus the extra
// generation read for a reused-slot create.
// A stalled result is held in the output register; the next request is
// still taken and processed, and waits in its last step until the register
// is free.
// Reset clears the counters and the result valid; slot stores need no clear.
`include "assert_macros.svh"

module generational_handle_allocator_unit #(
  parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // handle_slot[9:0], handle_generation[41:10], group_index[49:42],
  // page_number[65:50], row_number[81:66], zero fill above
  input  logic [gha_pkg::DATA_W-1:0]   s_tdata,
  // mode
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // slot_out[9:0], generation_out[41:10], group_out[49:42],
  // page_out[65:50], row_out[81:66], zero fill above
  output logic [gha_pkg::DATA_W-1:0]   m_tdata,
  // status
  output logic [gha_pkg::STATUS_W-1:0] m_tuser
);

  localparam int CNT_W = $clog2(SLOTS+1);

  gha_pkg::cmd_t    cmd;
  gha_pkg::stat_t   stat;
  logic [CNT_W-1:0] used_cnt;
  logic [CNT_W-1:0] free_cnt;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gha_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .used_cnt (used_cnt),
    .free_cnt (free_cnt)
  );

  // Checks
  `ASSERT_CLK(a_one_at_a_time, clk, rst, s_tvalid && s_tready |=> !s_tready, "request accepted while busy")
  `ASSERT_CLK(a_used_monotonic, clk, rst, 1'b1 |=> used_cnt >= $past(used_cnt), "used count decreased")
  `ASSERT_ALWAYS(a_counts_bounded, clk, rst, used_cnt <= CNT_W'(SLOTS) && free_cnt <= CNT_W'(SLOTS), "slot count out of range")

endmodule
